### hw/rtl/npcs_pkg.sv
package npcs_pkg;

  localparam int CH_W   = 8;
  localparam int RGB_W  = 3 * CH_W;
  localparam int SH_W   = 4;
  localparam int DIST_W = 15;

  // bound larger than any real distance (worst case is 765)
  localparam logic [DIST_W-1:0] DIST_INIT = 15'h7FFF;

  typedef enum logic [1:0] {
    CMD_WRITE  = 2'd0,
    CMD_SEARCH = 2'd1,
    CMD_SHADE  = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_t;

  typedef struct packed {
    logic [CH_W-1:0] r;
    logic [CH_W-1:0] g;
    logic [CH_W-1:0] b;
  } rgb_t;

  // (p * shade * 4 + 16) / 32, clamped at 255
  function automatic logic [CH_W-1:0] scale_channel(input logic [CH_W-1:0] p,
                                                    input logic [SH_W-1:0] shade);
    logic [13:0] prod;
    logic [8:0]  v;
    prod = 14'(p) * 14'({shade, 2'b00});
    v    = 9'((prod + 14'd16) >> 5);
    return (v > 9'd255) ? 8'hFF : v[CH_W-1:0];
  endfunction

  function automatic logic [CH_W-1:0] abs_diff(input logic [CH_W-1:0] a,
                                               input logic [CH_W-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

### hw/rtl/nearest_palette_color_search.sv
// nearest palette color search
//
// item channel (item_valid / item_stall): one beat carries cmd, entry_index,
// red, green, blue and shade_level. a write beat stores one palette entry and
// gives no result; cmd 3 is dropped. a search beat scans the
// whole palette through the single read port of the palette memory, one
// entry per cycle, with one shared distance/compare unit.
// a shade search first reads the entry at entry_index and scales it by
// shade_level in a shade state; the scaled color is the query. one write
// per cycle is taken while no search runs. item_stall is high while a
// search runs and while its result waits.
// result channel (result_valid / result_stall): nearest_index sits in an
// output register; while the receiver stalls it holds, and the block keeps
// taking writes. a finished search waits for the register to free up.
// reset clears the sequencer and result_valid. the palette is not cleared:
// every entry must be written before the first search.
module nearest_palette_color_search #(
  parameter int ENTRIES = 256
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_stall,
  input  logic [1:0] cmd,
  input  logic [7:0] entry_index,
  input  logic [7:0] red,
  input  logic [7:0] green,
  input  logic [7:0] blue,
  input  logic [3:0] shade_level,
  output logic       result_valid,
  input  logic       result_stall,
  output logic [7:0] nearest_index
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST = IDX_W'(ENTRIES - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHADE,
    S_SCAN,
    S_DRAIN,
    S_OUT
  } state_t;

  state_t                   state;
  logic [IDX_W-1:0]         cnt;
  npcs_pkg::rgb_t           query;
  logic [npcs_pkg::SH_W-1:0] shade;
  logic                     shade_ok;
  logic                     cmp_valid;
  logic [IDX_W-1:0]         cmp_idx;
  logic [npcs_pkg::DIST_W-1:0] best;
  logic [IDX_W-1:0]         best_idx;

  logic                     accept;
  logic                     in_range;
  logic                     mem_we;
  logic [IDX_W-1:0]         mem_rd_addr;
  npcs_pkg::rgb_t           mem_wr_data;
  npcs_pkg::rgb_t           mem_rd_data;
  npcs_pkg::rgb_t           shaded;
  logic [9:0]               dist_sum;
  logic                     better;

  assign item_stall = (state != S_IDLE);
  assign accept     = item_valid && !item_stall;
  assign in_range   = (32'(entry_index) < 32'(ENTRIES));
  assign mem_we     = accept && (npcs_pkg::cmd_t'(cmd) == npcs_pkg::CMD_WRITE) && in_range;
  assign mem_wr_data = '{r: red, g: green, b: blue};
  assign mem_rd_addr = (state == S_IDLE) ? IDX_W'(entry_index) : cnt;

  npcs_palette_ram #(
    .DEPTH  (ENTRIES),
    .ADDR_W (IDX_W)
  ) u_ram (
    .clk     (clk),
    .we      (mem_we),
    .wr_addr (IDX_W'(entry_index)),
    .wr_data (mem_wr_data),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  // shaded query: an index beyond the palette scales black
  always_comb begin
    shaded.r = shade_ok ? npcs_pkg::scale_channel(mem_rd_data.r, shade) : '0;
    shaded.g = shade_ok ? npcs_pkg::scale_channel(mem_rd_data.g, shade) : '0;
    shaded.b = shade_ok ? npcs_pkg::scale_channel(mem_rd_data.b, shade) : '0;
  end

  // shared distance and compare unit
  assign dist_sum = 10'(npcs_pkg::abs_diff(query.r, mem_rd_data.r))
                  + 10'(npcs_pkg::abs_diff(query.g, mem_rd_data.g))
                  + 10'(npcs_pkg::abs_diff(query.b, mem_rd_data.b));
  assign better = cmp_valid && (npcs_pkg::DIST_W'(dist_sum) < best);

  always_ff @(posedge clk) begin
    cmp_valid <= (state == S_SCAN);
    cmp_idx   <= cnt;
    if (better) begin
      best     <= npcs_pkg::DIST_W'(dist_sum);
      best_idx <= cmp_idx;
    end
    if (result_valid && !result_stall) begin
      result_valid <= 1'b0;
    end
    unique case (state)
      S_IDLE: begin
        cnt  <= '0;
        best <= npcs_pkg::DIST_INIT;
        if (accept) begin
          query    <= mem_wr_data;
          shade    <= shade_level;
          shade_ok <= in_range;
          case (npcs_pkg::cmd_t'(cmd))
            npcs_pkg::CMD_SEARCH: state <= S_SCAN;
            npcs_pkg::CMD_SHADE:  state <= S_SHADE;
            default:              state <= S_IDLE;
          endcase
        end
      end
      S_SHADE: begin
        query <= shaded;
        state <= S_SCAN;
      end
      S_SCAN: begin
        cnt <= cnt + 1'b1;
        if (cnt == LAST) begin
          state <= S_DRAIN;
        end
      end
      S_DRAIN: begin
        // last entry is compared in this cycle
        state <= S_OUT;
      end
      S_OUT: begin
        if (!result_valid || !result_stall) begin
          result_valid  <= 1'b1;
          nearest_index <= 8'(best_idx);
          state         <= S_IDLE;
        end
      end
      default: state <= S_IDLE;
    endcase
    if (rst) begin
      state        <= S_IDLE;
      cmp_valid    <= 1'b0;
      result_valid <= 1'b0;
    end
  end

endmodule

### hw/rtl/npcs_palette_ram.sv
module npcs_palette_ram #(
  parameter int DEPTH  = 256,
  parameter int ADDR_W = 8
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [ADDR_W-1:0]         wr_addr,
  input  npcs_pkg::rgb_t            wr_data,
  input  logic [ADDR_W-1:0]         rd_addr,
  output npcs_pkg::rgb_t            rd_data
);

  npcs_pkg::rgb_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### hw/rtl/npcs_checker.sv
module npcs_checker (
  input logic       clk,
  input logic       rst,
  input logic       item_valid,
  input logic       item_stall,
  input logic [1:0] cmd,
  input logic       result_valid,
  input logic       result_stall,
  input logic [7:0] nearest_index
);

  logic item_beat;
  assign item_beat = item_valid && !item_stall;

  // a stalled result beat holds its value
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(nearest_index))
    else $error("result changed while stalled");

  // a search keeps the item side busy afterwards
  a_search_busy: assert property (@(posedge clk) disable iff (rst)
    item_beat && (cmd == npcs_pkg::CMD_SEARCH || cmd == npcs_pkg::CMD_SHADE)
    |=> item_stall)
    else $error("search accepted but item side not busy");

  // writes and dropped commands never make a result
  a_write_no_result: assert property (@(posedge clk) disable iff (rst)
    item_beat && !result_valid &&
    (cmd == npcs_pkg::CMD_WRITE || cmd == npcs_pkg::CMD_NOP)
    |=> !result_valid)
    else $error("result without a search");

  // a new result only comes out of a running search
  a_result_from_search: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(item_stall))
    else $error("result appeared while idle");

endmodule

bind nearest_palette_color_search npcs_checker u_npcs_checker (
  .clk           (clk),
  .rst           (rst),
  .item_valid    (item_valid),
  .item_stall    (item_stall),
  .cmd           (cmd),
  .result_valid  (result_valid),
  .result_stall  (result_stall),
  .nearest_index (nearest_index)
);
